@@ src/ccr_pkg.sv @@
// ----------------------------------------------------------------------------
// ccr_pkg - shared types and constants of the Catmull-Rom evaluator
// Operation codes, fixed field widths, the four-point window that the
// front end hands to the arithmetic back end, and the queue depth.
// ----------------------------------------------------------------------------
package ccr_pkg;

   // fixed field widths
   localparam int COORD_W  = 32;   // Q16.16 coordinate
   localparam int COEF_W   = 36;   // blend coefficients, up to 12 * 2^31
   localparam int ACC_W    = 40;   // Horner accumulator
   localparam int INDEX_W  = 8;    // point slot field
   localparam int COUNT_W  = 9;    // point_count register
   localparam int SEG_W    = 8;    // segment field
   localparam int LANES    = 4;    // points per window, also RAM banks

   // decoupling queue
   localparam int QUEUE_DEPTH = 8;
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // request operations
   localparam logic OP_LOAD = 1'b0;
   localparam logic OP_EVAL = 1'b1;

   typedef logic signed [COORD_W-1:0] coord_type;

   // four neighboring points of one segment, lane 0 is p0
   typedef struct packed {
      coord_type [LANES-1:0] x;
      coord_type [LANES-1:0] y;
      logic [SEG_W-1:0]      seg;
   } window_type;

endpackage

@@ src/ccr_ram.sv @@
// ----------------------------------------------------------------------------
// ccr_ram - generic single-write, single-read RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module ccr_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 64
) (
   input  logic                                   clock,
   input  logic                                   wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                       wr_data,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                       rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ src/ccr_front.sv @@
// ----------------------------------------------------------------------------
// ccr_front - request intake, segment selection and point fetch
// Accepts requests, writes loads into four interleaved point banks, turns
// t into segment and local u, fetches the four points and pushes a window.
// ----------------------------------------------------------------------------
module ccr_front #(
   parameter int MAX_POINTS  = 256,
   parameter int T_FRAC_BITS = 16
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic                            req_op,
   input  logic [ccr_pkg::INDEX_W-1:0]     req_point_index,
   input  logic signed [ccr_pkg::COORD_W-1:0] req_point_x,
   input  logic signed [ccr_pkg::COORD_W-1:0] req_point_y,
   input  logic [T_FRAC_BITS:0]            req_curve_t,
   input  logic [ccr_pkg::COUNT_W-1:0]     point_count,
   input  logic                            pop,
   output logic                            push_valid,
   output ccr_pkg::window_type             push_window,
   output logic [T_FRAC_BITS:0]            push_u
);
   import ccr_pkg::*;

   localparam int ONE        = 1 << T_FRAC_BITS;
   localparam int T_W        = T_FRAC_BITS + 1;
   localparam int SC_W       = T_W + COUNT_W;
   localparam int IDX_W      = COUNT_W + 1;
   localparam int BANK_DEPTH = (MAX_POINTS + LANES - 1) / LANES;
   localparam int BA_W       = BANK_DEPTH > 1 ? $clog2(BANK_DEPTH) : 1;

   logic accept;
   logic [QCNT_W-1:0] credit_ff, credit_in;

   // stage A: accepted request
   logic                 a_valid_ff, a_op_ff;
   logic [INDEX_W-1:0]   a_idx_ff;
   logic [COORD_W-1:0]   a_x_ff, a_y_ff;
   logic [SC_W-1:0]      a_scaled_ff;
   logic [COUNT_W-1:0]   a_segs_ff;

   // stage B: fetch issued
   logic                 b_valid_ff;
   logic [COUNT_W-1:0]   b_seg_ff;
   logic [T_W-1:0]       b_u_ff;
   logic [1:0]           b_rot_ff;

   logic [COUNT_W-1:0]   n_clamp, segs;
   logic [T_W-1:0]       t_clamp;
   logic [SC_W-1:0]      scaled;
   logic [IDX_W-1:0]     seg_hi;
   logic                 end_hit, load_hit;
   logic [COUNT_W-1:0]   seg_b;
   logic [T_W-1:0]       u_b;
   logic [BA_W-1:0]      rd_addr [LANES];
   logic [BA_W-1:0]      wr_addr;
   logic                 wr_en [LANES];
   logic [2*COORD_W-1:0] rd_data [LANES];

   // evaluates hold a queue credit from intake until the back end pops them
   assign req_ready = credit_ff < QCNT_W'(QUEUE_DEPTH);
   assign accept    = req_valid && req_ready;

   always_comb begin
      credit_in = credit_ff;
      if (accept && req_op == OP_EVAL) begin
         credit_in = credit_in + QCNT_W'(1);
      end
      if (pop) begin
         credit_in = credit_in - QCNT_W'(1);
      end
   end

   // clamp point count and t, scale t by segment count
   always_comb begin
      if (point_count < COUNT_W'(LANES)) begin
         n_clamp = COUNT_W'(LANES);
      end else if (int'(point_count) > MAX_POINTS) begin
         n_clamp = COUNT_W'(MAX_POINTS);
      end else begin
         n_clamp = point_count;
      end
      segs    = n_clamp - COUNT_W'(3);
      t_clamp = (req_curve_t > T_W'(ONE)) ? T_W'(ONE) : req_curve_t;
      scaled  = SC_W'(t_clamp) * SC_W'(segs);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         credit_ff  <= '0;
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
      end else begin
         credit_ff  <= credit_in;
         a_valid_ff <= accept;
         b_valid_ff <= a_valid_ff && a_op_ff == OP_EVAL;
      end
   end

   always_ff @(posedge clock) begin
      a_op_ff     <= req_op;
      a_idx_ff    <= req_point_index;
      a_x_ff      <= req_point_x;
      a_y_ff      <= req_point_y;
      a_scaled_ff <= scaled;
      a_segs_ff   <= segs;
      b_seg_ff    <= seg_b;
      b_u_ff      <= u_b;
      b_rot_ff    <= seg_b[1:0];
   end

   // split scaled t; past the last segment use its end
   always_comb begin
      seg_hi  = a_scaled_ff[SC_W-1:T_FRAC_BITS];
      end_hit = seg_hi >= {1'b0, a_segs_ff};
      if (end_hit) begin
         seg_b = a_segs_ff - COUNT_W'(1);
         u_b   = T_W'(ONE);
      end else begin
         seg_b = seg_hi[COUNT_W-1:0];
         u_b   = {1'b0, a_scaled_ff[T_FRAC_BITS-1:0]};
      end
   end

   // bank b holds slots with index mod 4 == b
   assign load_hit = a_valid_ff && a_op_ff == OP_LOAD && int'(a_idx_ff) < MAX_POINTS;
   assign wr_addr  = BA_W'(a_idx_ff >> 2);

   for (genvar b = 0; b < LANES; b++) begin : g_bank
      logic [1:0]       offs;
      logic [IDX_W-1:0] idx;

      always_comb begin
         offs        = 2'(b) - seg_b[1:0];
         idx         = {1'b0, seg_b} + IDX_W'(offs);
         rd_addr[b]  = BA_W'(idx >> 2);
         wr_en[b]    = load_hit && a_idx_ff[1:0] == 2'(b);
      end

      ccr_ram #(
         .WIDTH (2 * COORD_W),
         .DEPTH (BANK_DEPTH)
      ) u_bank (
         .clock   (clock),
         .wr_en   (wr_en[b]),
         .wr_addr (wr_addr),
         .wr_data ({a_x_ff, a_y_ff}),
         .rd_addr (rd_addr[b]),
         .rd_data (rd_data[b])
      );
   end

   // stage C: rotate bank outputs into p0..p3
   always_comb begin
      logic [1:0] sel;
      push_window.seg = b_seg_ff[SEG_W-1:0];
      for (int k = 0; k < LANES; k++) begin
         sel = b_rot_ff + 2'(k);
         push_window.x[k] = rd_data[sel][2*COORD_W-1:COORD_W];
         push_window.y[k] = rd_data[sel][COORD_W-1:0];
      end
   end

   assign push_valid = b_valid_ff;
   assign push_u     = b_u_ff;

endmodule

@@ src/ccr_queue.sv @@
// ----------------------------------------------------------------------------
// ccr_queue - decoupling queue between front and back end
// Register FIFO; the front end's credit count keeps it from overflowing.
// ----------------------------------------------------------------------------
module ccr_queue #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   input  logic             pop,
   output logic             pop_valid,
   output logic [WIDTH-1:0] pop_data
);

   localparam int PTR_W = DEPTH > 1 ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PTR_W-1:0] wptr_ff, rptr_ff;
   logic [CNT_W-1:0] count_ff, count_in;

   function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
      return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
   endfunction

   always_comb begin
      count_in = count_ff;
      if (push) begin
         count_in = count_in + CNT_W'(1);
      end
      if (pop) begin
         count_in = count_in - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff  <= '0;
         rptr_ff  <= '0;
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
         if (push) begin
            wptr_ff <= next_ptr(wptr_ff);
         end
         if (pop) begin
            rptr_ff <= next_ptr(rptr_ff);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wptr_ff] <= push_data;
      end
   end

   assign pop_valid = count_ff != '0;
   assign pop_data  = mem_ff[rptr_ff];

endmodule

@@ src/ccr_back.sv @@
// ----------------------------------------------------------------------------
// ccr_back - cubic blend pipeline
// Coefficients, three Horner steps (multiply, then round and add), final
// halving with saturation and the response register. Stalls as a whole.
// ----------------------------------------------------------------------------
module ccr_back #(
   parameter int T_FRAC_BITS = 16
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               job_valid,
   input  ccr_pkg::window_type                job_window,
   input  logic [T_FRAC_BITS:0]               job_u,
   output logic                               pop,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic signed [ccr_pkg::COORD_W-1:0] rsp_curve_x,
   output logic signed [ccr_pkg::COORD_W-1:0] rsp_curve_y,
   output logic [ccr_pkg::SEG_W-1:0]          rsp_segment
);
   import ccr_pkg::*;

   localparam int T_W  = T_FRAC_BITS + 1;
   localparam int P_W  = ACC_W + T_W + 1;
   localparam int HALF = 1 << (T_FRAC_BITS - 1);
   localparam int NSTG = 7;
   localparam int USTG = 5;   // u is last used by the third multiply

   logic en;
   logic [NSTG-1:0] v_ff;
   logic [T_W-1:0]  u_ff   [USTG];
   logic [SEG_W-1:0] seg_ff [NSTG];

   logic signed [COEF_W-1:0] s1_a0_ff [2], s1_a1_ff [2], s1_a2_ff [2], s1_a3_ff [2];
   logic signed [COEF_W-1:0] a0_c [2], a1_c [2], a2_c [2], a3_c [2];
   logic signed [P_W-1:0]    s2_m_ff [2], s4_m_ff [2], s6_m_ff [2];
   logic signed [COEF_W-1:0] s2_a0_ff [2], s2_a1_ff [2], s2_a2_ff [2];
   logic signed [COEF_W-1:0] s3_a0_ff [2], s3_a1_ff [2];
   logic signed [COEF_W-1:0] s4_a0_ff [2], s4_a1_ff [2];
   logic signed [COEF_W-1:0] s5_a0_ff [2], s6_a0_ff [2];
   logic signed [ACC_W-1:0]  s3_h_ff [2], s5_h_ff [2], s7_h_ff [2];
   logic signed [COORD_W-1:0] res_c [2];

   logic                      rsp_valid_ff;
   logic signed [COORD_W-1:0] rsp_x_ff, rsp_y_ff;
   logic [SEG_W-1:0]          rsp_seg_ff;

   // round to nearest, ties up, then drop the fraction
   function automatic logic signed [ACC_W-1:0] rnd(input logic signed [P_W-1:0] v);
      logic signed [P_W-1:0] r;
      r = (v + $signed(P_W'(HALF))) >>> T_FRAC_BITS;
      return r[ACC_W-1:0];
   endfunction

   function automatic logic signed [P_W-1:0] mul_u(input logic signed [ACC_W-1:0] h,
                                                   input logic [T_W-1:0] u);
      logic signed [T_W:0] us;
      logic signed [P_W-1:0] hp;
      us = $signed({1'b0, u});
      hp = P_W'(h);
      return hp * P_W'(us);
   endfunction

   // whole pipeline advances unless the response is held
   assign en  = !(rsp_valid_ff && !rsp_ready);
   assign pop = en && job_valid;

   // blend coefficients per axis
   always_comb begin
      logic signed [COEF_W-1:0] p0, p1, p2, p3;
      for (int ax = 0; ax < 2; ax++) begin
         if (ax == 0) begin
            p0 = COEF_W'($signed(job_window.x[0]));
            p1 = COEF_W'($signed(job_window.x[1]));
            p2 = COEF_W'($signed(job_window.x[2]));
            p3 = COEF_W'($signed(job_window.x[3]));
         end else begin
            p0 = COEF_W'($signed(job_window.y[0]));
            p1 = COEF_W'($signed(job_window.y[1]));
            p2 = COEF_W'($signed(job_window.y[2]));
            p3 = COEF_W'($signed(job_window.y[3]));
         end
         a0_c[ax] = p1 <<< 1;
         a1_c[ax] = p2 - p0;
         a2_c[ax] = (p0 <<< 1) - (p1 <<< 2) - p1 + (p2 <<< 2) - p3;
         a3_c[ax] = (p1 <<< 1) + p1 - (p2 <<< 1) - p2 + p3 - p0;
      end
   end

   // halve with round half up, saturate to 32 bits
   always_comb begin
      logic signed [ACC_W-1:0] f;
      for (int ax = 0; ax < 2; ax++) begin
         f = (s7_h_ff[ax] + ACC_W'(1)) >>> 1;
         if (f[ACC_W-1:COORD_W-1] == '0 || f[ACC_W-1:COORD_W-1] == '1) begin
            res_c[ax] = f[COORD_W-1:0];
         end else if (f[ACC_W-1]) begin
            res_c[ax] = {1'b1, {(COORD_W-1){1'b0}}};
         end else begin
            res_c[ax] = {1'b0, {(COORD_W-1){1'b1}}};
         end
      end
   end

   // stage valids and response valid
   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff         <= '0;
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         v_ff         <= {v_ff[NSTG-2:0], job_valid};
         rsp_valid_ff <= v_ff[NSTG-1];
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      if (en) begin
         u_ff[0]   <= job_u;
         seg_ff[0] <= job_window.seg;
         for (int s = 1; s < USTG; s++) begin
            u_ff[s] <= u_ff[s-1];
         end
         for (int s = 1; s < NSTG; s++) begin
            seg_ff[s] <= seg_ff[s-1];
         end
         for (int ax = 0; ax < 2; ax++) begin
            s1_a0_ff[ax] <= a0_c[ax];
            s1_a1_ff[ax] <= a1_c[ax];
            s1_a2_ff[ax] <= a2_c[ax];
            s1_a3_ff[ax] <= a3_c[ax];
            // Horner step one
            s2_m_ff[ax]  <= mul_u(ACC_W'(s1_a3_ff[ax]), u_ff[0]);
            s2_a0_ff[ax] <= s1_a0_ff[ax];
            s2_a1_ff[ax] <= s1_a1_ff[ax];
            s2_a2_ff[ax] <= s1_a2_ff[ax];
            s3_h_ff[ax]  <= rnd(s2_m_ff[ax]) + ACC_W'(s2_a2_ff[ax]);
            s3_a0_ff[ax] <= s2_a0_ff[ax];
            s3_a1_ff[ax] <= s2_a1_ff[ax];
            // Horner step two
            s4_m_ff[ax]  <= mul_u(s3_h_ff[ax], u_ff[2]);
            s4_a0_ff[ax] <= s3_a0_ff[ax];
            s4_a1_ff[ax] <= s3_a1_ff[ax];
            s5_h_ff[ax]  <= rnd(s4_m_ff[ax]) + ACC_W'(s4_a1_ff[ax]);
            s5_a0_ff[ax] <= s4_a0_ff[ax];
            // Horner step three
            s6_m_ff[ax]  <= mul_u(s5_h_ff[ax], u_ff[4]);
            s6_a0_ff[ax] <= s5_a0_ff[ax];
            s7_h_ff[ax]  <= rnd(s6_m_ff[ax]) + ACC_W'(s6_a0_ff[ax]);
         end
         rsp_x_ff   <= res_c[0];
         rsp_y_ff   <= res_c[1];
         rsp_seg_ff <= seg_ff[NSTG-1];
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_curve_x = rsp_x_ff;
   assign rsp_curve_y = rsp_y_ff;
   assign rsp_segment = rsp_seg_ff;

endmodule

@@ src/catmull_rom_curve_evaluator.sv @@
// An evaluate passes front stages A and B, the queue and the back-end pipeline.
// Throughput: one request per cycle while a credit is free; evaluates hold one of
// 8 queue credits until the back end pops them; loads give no response.
// Reset: synchronous; clears pipeline valids, queue and credits, point_count = 4.
// The point store is not cleared; slots must be loaded before they are used.
// ----------------------------------------------------------------------------
// catmull_rom_curve_evaluator - uniform Catmull-Rom spline evaluator
// Front end stores points and fetches segment windows, a queue decouples it
// from the pipelined cubic blend in the back end.
// ----------------------------------------------------------------------------
module catmull_rom_curve_evaluator #(
   parameter int MAX_POINTS  = 256,
   parameter int T_FRAC_BITS = 16
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [ccr_pkg::COUNT_W-1:0]        csr_point_count,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic                               req_op,
   input  logic [ccr_pkg::INDEX_W-1:0]        req_point_index,
   input  logic signed [ccr_pkg::COORD_W-1:0] req_point_x,
   input  logic signed [ccr_pkg::COORD_W-1:0] req_point_y,
   input  logic [T_FRAC_BITS:0]               req_curve_t,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic signed [ccr_pkg::COORD_W-1:0] rsp_curve_x,
   output logic signed [ccr_pkg::COORD_W-1:0] rsp_curve_y,
   output logic [ccr_pkg::SEG_W-1:0]          rsp_segment
);
   import ccr_pkg::*;

   localparam int T_W   = T_FRAC_BITS + 1;
   localparam int JOB_W = $bits(window_type) + T_W;

   logic [COUNT_W-1:0] point_count_ff;
   logic               push_valid, pop, job_valid;
   window_type         push_window, job_window;
   logic [T_W-1:0]     push_u, job_u;
   logic [JOB_W-1:0]   job_data;

   // configuration register
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         point_count_ff <= COUNT_W'(LANES);
      end else if (csr_valid) begin
         point_count_ff <= csr_point_count;
      end
   end

   ccr_front #(
      .MAX_POINTS  (MAX_POINTS),
      .T_FRAC_BITS (T_FRAC_BITS)
   ) u_front (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_op          (req_op),
      .req_point_index (req_point_index),
      .req_point_x     (req_point_x),
      .req_point_y     (req_point_y),
      .req_curve_t     (req_curve_t),
      .point_count     (point_count_ff),
      .pop             (pop),
      .push_valid      (push_valid),
      .push_window     (push_window),
      .push_u          (push_u)
   );

   ccr_queue #(
      .WIDTH (JOB_W),
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push_valid),
      .push_data ({push_window, push_u}),
      .pop       (pop),
      .pop_valid (job_valid),
      .pop_data  (job_data)
   );

   assign job_window = job_data[JOB_W-1:T_W];
   assign job_u      = job_data[T_W-1:0];

   ccr_back #(
      .T_FRAC_BITS (T_FRAC_BITS)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .job_valid   (job_valid),
      .job_window  (job_window),
      .job_u       (job_u),
      .pop         (pop),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_curve_x (rsp_curve_x),
      .rsp_curve_y (rsp_curve_y),
      .rsp_segment (rsp_segment)
   );

endmodule

@@ tb/catmull_rom_curve_evaluator_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// catmull_rom_curve_evaluator_tb - self-checking bench of the spline evaluator
// The control point store is first loaded, then a table of directed requests
// is run, followed by random load/evaluate traffic over several point counts.
// Responses are checked against a bit-exact Catmull-Rom predictor.
// ----------------------------------------------------------------------------
module catmull_rom_curve_evaluator_tb;
   import ccr_pkg::*;

   localparam int CMAX      = 32'h7FFFFFFF;
   localparam int CMIN      = 32'h80000000;
   localparam int T_ONE     = 65536;
   localparam int SETTLE    = 16;
   localparam int IDLE_MAX  = 5000;
   localparam int HOLD_LEN  = 300;
   localparam int PHASE_LEN = 150;

   typedef struct {
      int        x;
      int        y;
      bit [7:0]  seg;
   } curve_pt_type;

   typedef struct {
      logic       op;
      bit [7:0]   idx;
      int         x;
      int         y;
      bit [16:0]  t;
      bit         known;
      int         ex;
      int         ey;
      bit [7:0]   eseg;
   } row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [COUNT_W-1:0] csr_point_count = '0;
   logic req_valid = 1'b0;
   logic req_ready;
   logic req_op = OP_LOAD;
   logic [INDEX_W-1:0] req_point_index = '0;
   logic signed [COORD_W-1:0] req_point_x = '0;
   logic signed [COORD_W-1:0] req_point_y = '0;
   logic [16:0] req_curve_t = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic signed [COORD_W-1:0] rsp_curve_x;
   logic signed [COORD_W-1:0] rsp_curve_y;
   logic [SEG_W-1:0] rsp_segment;

   // predictor state
   int           store_x [256];
   int           store_y [256];
   bit [8:0]     count_reg = 9'd4;
   curve_pt_type pending_pts[$];

   int  errors = 0;
   bit  quiet = 1'b0;
   bit  hold_start = 1'b0;
   int  hold_cnt = 0;
   int  stall_cnt = 0;
   int  idle_cycles = 0;

   catmull_rom_curve_evaluator dut (
      .clock(clock), .reset(reset),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_point_count(csr_point_count),
      .req_valid(req_valid), .req_ready(req_ready), .req_op(req_op),
      .req_point_index(req_point_index), .req_point_x(req_point_x),
      .req_point_y(req_point_y), .req_curve_t(req_curve_t),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_curve_x(rsp_curve_x),
      .rsp_curve_y(rsp_curve_y), .rsp_segment(rsp_segment)
   );

   always #5 clock = ~clock;

   // product rescale, round half up
   function automatic longint round_q(longint v);
      return (v + 32768) >>> 16;
   endfunction

   // one axis of the cubic blend, saturated to 32 bits
   function automatic int blend_axis(longint p0, longint p1, longint p2, longint p3,
                                     longint u);
      longint a0, a1, a2, a3, h;
      a0 = 2 * p1;
      a1 = p2 - p0;
      a2 = 2 * p0 - 5 * p1 + 4 * p2 - p3;
      a3 = -p0 + 3 * p1 - 3 * p2 + p3;
      h = round_q(a3 * u) + a2;
      h = round_q(h * u) + a1;
      h = round_q(h * u) + a0;
      h = (h + 1) >>> 1;
      if (h > 64'sd2147483647) h = 64'sd2147483647;
      if (h < -64'sd2147483648) h = -64'sd2147483648;
      return int'(h);
   endfunction

   function automatic curve_pt_type curve_point(bit [16:0] t_in);
      curve_pt_type r;
      longint n, segs, t, scaled, seg, u;
      n = count_reg;
      if (n < 4) n = 4;
      if (n > 256) n = 256;
      segs = n - 3;
      t = t_in;
      if (t > T_ONE) t = T_ONE;
      scaled = t * segs;
      seg = scaled >> 16;
      if (seg >= segs) begin
         seg = segs - 1;
         u = T_ONE;
      end else begin
         u = scaled & 64'hFFFF;
      end
      r.x = blend_axis(store_x[seg], store_x[seg+1], store_x[seg+2], store_x[seg+3], u);
      r.y = blend_axis(store_y[seg], store_y[seg+1], store_y[seg+2], store_y[seg+3], u);
      r.seg = seg[7:0];
      return r;
   endfunction

   task automatic report_mismatch(string what, longint got, longint want);
      $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
      errors++;
   endtask

   // drive one request, optional idle gap before it
   task automatic send_request(row_type r);
      curve_pt_type e;
      if (!quiet && $urandom_range(0, 5) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 9)) @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_op          <= r.op;
      req_point_index <= r.idx;
      req_point_x     <= r.x;
      req_point_y     <= r.y;
      req_curve_t     <= r.t;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      if (r.op == OP_LOAD) begin
         store_x[r.idx] = r.x;
         store_y[r.idx] = r.y;
      end else if (r.known) begin
         e.x = r.ex;
         e.y = r.ey;
         e.seg = r.eseg;
         pending_pts = {pending_pts, e};
      end else begin
         pending_pts = {pending_pts, curve_point(r.t)};
      end
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_pts.size() != 0) @(posedge clock);
   endtask

   // register write only with the block idle
   task automatic write_count(bit [8:0] v);
      wait_drained();
      repeat (SETTLE) @(posedge clock);
      csr_valid       <= 1'b1;
      csr_point_count <= v;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      count_reg = v;
   endtask

   function automatic int rand_coord();
      case ($urandom_range(0, 9))
         0: return CMAX;
         1: return CMIN;
         2: return int'($urandom_range(0, 511)) - 256;
         default: return int'($urandom);
      endcase
   endfunction

   function automatic row_type rand_row();
      row_type r;
      r.known = 1'b0;
      r.ex = 0;
      r.ey = 0;
      r.eseg = '0;
      r.op = ($urandom_range(0, 4) == 0) ? OP_LOAD : OP_EVAL;
      r.idx = 8'($urandom_range(0, 255));
      r.x = rand_coord();
      r.y = rand_coord();
      case ($urandom_range(0, 9))
         0: r.t = 17'd0;
         1: r.t = 17'(T_ONE);
         2: r.t = 17'($urandom_range(T_ONE + 1, 131071));
         default: r.t = 17'($urandom_range(0, T_ONE - 1));
      endcase
      return r;
   endfunction

   // response receiver: random stalls, one long hold-off on request
   always @(posedge clock) begin
      if (hold_start) begin
         hold_start = 1'b0;
         hold_cnt = HOLD_LEN;
      end
      if (hold_cnt > 0) begin
         hold_cnt--;
         rsp_ready <= 1'b0;
      end else if (stall_cnt > 0) begin
         stall_cnt--;
         rsp_ready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
         stall_cnt = int'($urandom_range(0, 8));
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // response checker
   always @(posedge clock) begin
      curve_pt_type e;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_pts.size() == 0) begin
            $display("unexpected response at %0t", $realtime);
            errors++;
         end else begin
            e = pending_pts.pop_front();
            if (rsp_curve_x !== e.x) report_mismatch("curve_x", rsp_curve_x, e.x);
            if (rsp_curve_y !== e.y) report_mismatch("curve_y", rsp_curve_y, e.y);
            if (rsp_segment !== e.seg) report_mismatch("segment", rsp_segment, e.seg);
         end
      end
   end

   // watchdog on cycles without any handshake
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (csr_valid && csr_ready)
          || reset)
         idle_cycles = 0;
      else
         idle_cycles++;
      if (idle_cycles >= IDLE_MAX) begin
         $display("tb: failure");
         $finish;
      end
   end

   initial begin
      row_type directed[$];
      row_type r;
      bit [8:0] phase_counts[8];
      int i, p;

      phase_counts = '{9'd4, 9'd256, 9'd0, 9'd511, 9'd7, 9'd257, 9'd3, 9'd4};
      phase_counts[7] = 9'($urandom_range(5, 255));

      // point_count reset value is 4; segment 0 covers slots 0..3
      directed = '{
         '{OP_LOAD, 8'd0, CMIN, CMAX, 17'd0, 0, 0, 0, 8'd0},
         '{OP_LOAD, 8'd1, CMAX, CMIN, 17'd0, 0, 0, 0, 8'd0},
         '{OP_LOAD, 8'd2, CMAX, CMIN, 17'd0, 0, 0, 0, 8'd0},
         '{OP_LOAD, 8'd3, CMIN, CMAX, 17'd0, 0, 0, 0, 8'd0},
         '{OP_EVAL, 8'd0, 0, 0, 17'd0, 1, CMAX, CMIN, 8'd0},
         '{OP_EVAL, 8'd0, 0, 0, 17'd65536, 1, CMAX, CMIN, 8'd0},
         '{OP_EVAL, 8'd0, 0, 0, 17'h1FFFF, 1, CMAX, CMIN, 8'd0},
         '{OP_EVAL, 8'd0, 0, 0, 17'd32768, 0, 0, 0, 8'd0},
         '{OP_EVAL, 8'd0, 0, 0, 17'd1, 0, 0, 0, 8'd0},
         '{OP_EVAL, 8'd0, 0, 0, 17'd65535, 0, 0, 0, 8'd0},
         '{OP_LOAD, 8'd1, 0, 0, 17'd0, 0, 0, 0, 8'd0},
         '{OP_LOAD, 8'd2, -1, 1, 17'd0, 0, 0, 0, 8'd0},
         '{OP_EVAL, 8'd0, 0, 0, 17'd0, 1, 0, 0, 8'd0},
         '{OP_EVAL, 8'd0, 0, 0, 17'd65536, 1, -1, 1, 8'd0},
         '{OP_EVAL, 8'd0, 0, 0, 17'd16384, 0, 0, 0, 8'd0},
         '{OP_LOAD, 8'd255, CMAX, CMIN, 17'h1FFFF, 0, 0, 0, 8'd0},
         '{OP_LOAD, 8'd3, 32'h12345678, -5, 17'd0, 0, 0, 0, 8'd0},
         '{OP_EVAL, 8'd0, 0, 0, 17'd49152, 0, 0, 0, 8'd0}
      };

      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // fill every slot so no evaluate reads an unwritten point
      for (i = 0; i < 256; i++) begin
         r = rand_row();
         r.op = OP_LOAD;
         r.idx = 8'(i);
         send_request(r);
      end

      foreach (directed[k]) send_request(directed[k]);

      // random phases, one point count each
      for (p = 0; p < 8; p++) begin
         write_count(phase_counts[p]);
         if (p == 7) quiet = 1'b1;
         for (i = 0; i < PHASE_LEN; i++) begin
            if (p == 1 && i == 40) hold_start = 1'b1;
            if (p == 3 && i == 90) wait_drained();
            send_request(rand_row());
         end
      end

      wait_drained();
      repeat (SETTLE) @(posedge clock);
      if (errors == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule

@@ catmull_rom_curve_evaluator.f @@
src/ccr_pkg.sv
src/ccr_ram.sv
src/ccr_front.sv
src/ccr_queue.sv
src/ccr_back.sv
src/catmull_rom_curve_evaluator.sv
tb/catmull_rom_curve_evaluator_tb.sv
